### rtl/txt_pkg.sv
// Shared types, character codes and mode codes for the number-to-text formatter.
// Depends on nothing; imported by txt_bcd, txt_seq, number_to_text_formatter and tb_top.
package txt_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int MODE_W  = 3;
    localparam int BCD_DIGITS = 10;
    localparam int DIG_W   = 4 * BCD_DIGITS;   // digit shift register, nibble digits
    localparam int CNT_W   = 6;                // up to 32 binary digits
    localparam int STEP_W  = 5;                // 32 conversion steps

    localparam logic [MODE_W-1:0] MODE_UDEC = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEX  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BIN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SDEC = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIX  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_B     = 7'h62;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;

    localparam logic [CNT_W-1:0] NDIG_DEC = 6'd10;
    localparam logic [CNT_W-1:0] NDIG_HEX = 6'd8;
    localparam logic [CNT_W-1:0] NDIG_BIN = 6'd32;
    localparam logic [CNT_W-1:0] NDIG_FIX = 6'd7;
    // fixed point: the dot follows the third digit, i.e. when four remain
    localparam logic [CNT_W-1:0] FIX_DOT_AT = 6'd5;

    typedef enum logic [1:0] {
        KIND_DEC,
        KIND_HEX,
        KIND_BIN,
        KIND_FIX
    } txt_kind_t;

    typedef struct packed {
        logic                 valid;
        txt_kind_t            kind;
        logic                 neg;
        logic [DIG_W-1:0]     digits;   // most significant digit in the top bits
        logic [CNT_W-1:0]     ndig;
    } seq_load_t;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_W-1:0]    ch;
        logic                 last;
    } txt_char_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {3'b000, d};
        end else begin
            r = CH_A + {3'b000, d} - 7'd10;
        end
        return r;
    endfunction

endpackage

### rtl/txt_bcd.sv
// Binary to BCD converter, shift-and-add-3, one input bit per cycle.
// Depends on txt_pkg.
module txt_bcd
    import txt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] bin_in,
    output logic               busy,
    output logic               done,
    output logic [DIG_W-1:0]   bcd
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [DIG_W-1:0]   bcd_reg, bcd_next;
    logic [DIG_W-1:0]   adj;

    // each decimal digit corrected on its own before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = bin_in;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {adj[DIG_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {STEP_W{1'b1}}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### rtl/txt_seq.sv
// Character sequencer: sign or prefix, leading-zero skip (none in fixed mode), then one digit
// per cycle while adv is high, with a dot in fixed mode, out of a shift register. Depends on txt_pkg.
module txt_seq
    import txt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  seq_load_t load,
    input  logic      adv,      // output register can take a character
    output logic      busy,
    output txt_char_t chr
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_P0,
        ST_P1,
        ST_SKIP,
        ST_DIG,
        ST_DOT
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    txt_kind_t         kind_reg, kind_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]        nib;
    logic [DIG_W-1:0]  shifted;

    assign nib     = (kind_reg == KIND_BIN) ? {3'b000, dig_reg[DIG_W-1]} : dig_reg[DIG_W-1 -: 4];
    assign shifted = (kind_reg == KIND_BIN) ? {dig_reg[DIG_W-2:0], 1'b0}
                                            : {dig_reg[DIG_W-5:0], 4'b0000};

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        chr.valid  = 1'b0;
        chr.ch     = CH_ZERO;
        chr.last   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (load.valid) begin
                    kind_next = load.kind;
                    dig_next  = load.digits;
                    cnt_next  = load.ndig;
                    if (load.kind == KIND_HEX || load.kind == KIND_BIN) begin
                        state_next = ST_P0;
                    end else if (load.kind == KIND_FIX) begin
                        state_next = ST_DIG;
                    end else if (load.neg) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SIGN: begin
                chr.valid = 1'b1;
                chr.ch    = CH_MINUS;
                if (adv) begin
                    state_next = ST_SKIP;
                end
            end
            ST_P0: begin
                chr.valid = 1'b1;
                chr.ch    = CH_ZERO;
                if (adv) begin
                    state_next = ST_P1;
                end
            end
            ST_P1: begin
                chr.valid = 1'b1;
                chr.ch    = (kind_reg == KIND_HEX) ? CH_X : CH_B;
                if (adv) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // the last digit is always shown, so zero prints as "0"
                if (nib == 4'd0 && cnt_reg > 6'd1) begin
                    dig_next = shifted;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_DIG;
                end
            end
            ST_DIG: begin
                chr.valid = 1'b1;
                chr.ch    = digit_char(nib);
                chr.last  = (cnt_reg == 6'd1);
                if (adv) begin
                    dig_next = shifted;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1) begin
                        state_next = ST_IDLE;
                    end else if (kind_reg == KIND_FIX && cnt_reg == FIX_DOT_AT) begin
                        state_next = ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                chr.valid = 1'b1;
                chr.ch    = CH_DOT;
                if (adv) begin
                    state_next = ST_DIG;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        kind_reg <= kind_next;
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/number_to_text_formatter.sv
// Number to text formatter, top level: input control, BCD converter,
// character sequencer and output register. Depends on txt_pkg, txt_bcd, txt_seq.
//
// Usage: one item on the s_ channel carries a 32-bit value and a mode; the
// block answers with its ASCII text on the m_ channel, one character per
// item, most significant digit first, tlast on the final character.
// Modes: 0 unsigned decimal, 1 hex with "0x", 2 binary with "0b",
// 3 signed decimal, 4 fixed point ddd.dddd; other codes act as mode 0.
// Hex and binary go straight to the digit shift register; the sequencer then
// emits the prefix. Between prefix and digits the leading-zero skip drops up
// to 7 hex or 31 binary zero digits without emitting, then one character per
// cycle follows while the output register is not stalled.
// Decimal and fixed modes first pass the value through the shift-and-add-3
// converter, one bit per cycle; then a signed value's minus sign or the first
// fixed digit comes out. Decimal digits go through the same skip (up to 9 zeros).
// A new item is taken once the sequencer has handed over the last character
// of the previous text; that character may still wait in the output register.
// A stall on m_tready holds the output register and every sequencer state that
// shows a character. Reset (aresetn low, synchronous) empties the output register
// and returns every unit to idle; the data registers are not reset.
module number_to_text_formatter
    import txt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [2:0] mode, [34:3] value, [39:35] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [6:0] text_char, [7] zero
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_RUN
    } top_state_t;

    top_state_t        state_reg, state_next;
    txt_kind_t         kind_reg, kind_next;
    logic              neg_reg, neg_next;
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    logic [MODE_W-1:0]  in_mode;
    logic [VALUE_W-1:0] in_value;
    logic [VALUE_W-1:0] magnitude;
    logic               in_neg;
    txt_kind_t          in_kind;
    logic               accept;
    logic               adv;

    logic              bcd_start;
    logic              bcd_busy;
    logic              bcd_done;
    logic [DIG_W-1:0]  bcd;
    seq_load_t         seq_load;
    logic              seq_busy;
    txt_char_t         chr;

    assign in_mode   = s_tdata[MODE_W-1:0];
    assign in_value  = s_tdata[MODE_W +: VALUE_W];
    assign accept    = s_tvalid && s_tready;
    assign adv       = !m_tvalid_reg || m_tready;
    assign in_neg    = (in_mode == MODE_SDEC) && in_value[VALUE_W-1];
    assign magnitude = in_neg ? (~in_value + 1'b1) : in_value;

    always_comb begin
        case (in_mode)
            MODE_HEX: in_kind = KIND_HEX;
            MODE_BIN: in_kind = KIND_BIN;
            MODE_FIX: in_kind = KIND_FIX;
            default:  in_kind = KIND_DEC;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        neg_next        = neg_reg;
        bcd_start       = 1'b0;
        seq_load.valid  = 1'b0;
        seq_load.kind   = kind_reg;
        seq_load.neg    = neg_reg;
        seq_load.digits = bcd;
        seq_load.ndig   = NDIG_DEC;
        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    kind_next = in_kind;
                    neg_next  = in_neg;
                    if (in_kind == KIND_HEX || in_kind == KIND_BIN) begin
                        seq_load.valid  = 1'b1;
                        seq_load.kind   = in_kind;
                        seq_load.neg    = 1'b0;
                        seq_load.digits = {in_value, {(DIG_W-VALUE_W){1'b0}}};
                        seq_load.ndig   = (in_kind == KIND_HEX) ? NDIG_HEX : NDIG_BIN;
                        state_next      = T_RUN;
                    end else begin
                        bcd_start  = 1'b1;
                        state_next = T_CONV;
                    end
                end
            end
            T_CONV: begin
                if (bcd_done) begin
                    seq_load.valid = 1'b1;
                    if (kind_reg == KIND_FIX) begin
                        // lowest seven decimal digits: three integer, four fraction
                        seq_load.digits = {bcd[4*7-1:0], {(DIG_W-4*7){1'b0}}};
                        seq_load.ndig   = NDIG_FIX;
                    end
                    state_next = T_RUN;
                end
            end
            T_RUN: begin
                if (!seq_busy) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (adv) begin
                m_tvalid_reg <= chr.valid;
            end
        end
        kind_reg <= kind_next;
        neg_reg  <= neg_next;
        if (adv) begin
            char_reg <= chr.ch;
            last_reg <= chr.last;
        end
    end

    txt_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin_in  (magnitude),
        .busy    (bcd_busy),
        .done    (bcd_done),
        .bcd     (bcd)
    );

    txt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (seq_load),
        .adv     (adv),
        .busy    (seq_busy),
        .chr     (chr)
    );

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

    // the sequencer is never mid-text while a new item may be taken
    a_idle_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !seq_busy)
        else $error("sequencer busy while input is ready");

    // the converter only runs while its result is awaited
    a_bcd_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_busy |-> (state_reg == T_CONV))
        else $error("converter running outside conversion");

    // an accepted item always closes the input until its text is handed over
    a_accept_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened straight after an accept");

endmodule

### verif/tb_top.sv
// Self-checking testbench for number_to_text_formatter: drives values in all modes
// on the s_ stream and checks every character on the m_ stream against a local
// text predictor. Depends on rtl/txt_pkg.sv and rtl/number_to_text_formatter.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import txt_pkg::*;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_exp_t;

    // Expected text per accepted value, kept in arrival order
    class text_scoreboard;
        text_char_exp_t    expected_text[$];
        logic [CHAR_W-1:0] line_buf[$];
        int unsigned       chars_checked;
        int unsigned       values_noted;
        int unsigned       errors;

        function void add_char(logic [CHAR_W-1:0] ch);
            line_buf.push_back(ch);
        endfunction

        // repeated division, most significant digit emitted first
        function void add_digits(logic [VALUE_W-1:0] num, int unsigned radix);
            logic [3:0]        digs[32];
            logic [VALUE_W-1:0] rem;
            int                cnt;
            cnt = 0;
            do begin
                rem = num % radix;
                digs[cnt] = rem[3:0];
                cnt++;
                num = num / radix;
            end while (num != 0);
            while (cnt > 0) begin
                cnt--;
                if (digs[cnt] < 4'd10) begin
                    add_char(CH_ZERO + CHAR_W'(digs[cnt]));
                end else begin
                    add_char(CH_A + CHAR_W'(digs[cnt]) - CHAR_W'(10));
                end
            end
        endfunction

        function void note_value(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] v;
            logic [3:0]         fix_digs[7];
            int                 k;
            line_buf.delete();
            values_noted++;
            case (mode)
                MODE_HEX: begin
                    add_char(CH_ZERO);
                    add_char(CH_X);
                    add_digits(value, 16);
                end
                MODE_BIN: begin
                    add_char(CH_ZERO);
                    add_char(CH_B);
                    add_digits(value, 2);
                end
                MODE_SDEC: begin
                    if (value[VALUE_W-1]) begin
                        add_char(CH_MINUS);
                        add_digits(-value, 10);
                    end else begin
                        add_digits(value, 10);
                    end
                end
                MODE_FIX: begin
                    // seven digits kept, anything above the millions place dropped
                    v = value;
                    for (k = 6; k >= 0; k--) begin
                        fix_digs[k] = 4'(v % 10);
                        v = v / 10;
                    end
                    for (k = 0; k < 7; k++) begin
                        add_char(CH_ZERO + CHAR_W'(fix_digs[k]));
                        if (k == 2) begin
                            add_char(CH_DOT);
                        end
                    end
                end
                default: begin
                    add_digits(value, 10);
                end
            endcase
            foreach (line_buf[i]) begin
                expected_text.push_back('{ch: line_buf[i], last: (i == line_buf.size() - 1)});
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            text_char_exp_t e;
            chars_checked++;
            if (expected_text.size() == 0) begin
                $error("text_char: no character expected, got 0x%02h (last %0b)", ch, last);
                errors++;
                return;
            end
            e = expected_text.pop_front();
            if (ch !== e.ch) begin
                $error("text_char: expected 0x%02h, actual 0x%02h", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [2:0] mode, [34:3] value, [39:35] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [6:0] text_char, [7] zero
    logic        m_tlast;

    logic        hold_req;
    logic        stall_on;
    bit          gaps_on;

    text_scoreboard sb = new;

    // {value, mode}
    localparam logic [34:0] DIRECTED [22] = '{
        {32'h0000_0000, MODE_UDEC}, {32'hFFFF_FFFF, MODE_UDEC}, {32'd1000000000, MODE_UDEC},
        {32'h0000_0000, MODE_HEX},  {32'hFFFF_FFFF, MODE_HEX},  {32'h0ABC_DEF9, MODE_HEX},
        {32'h0000_0000, MODE_BIN},  {32'hFFFF_FFFF, MODE_BIN},  {32'h0000_0001, MODE_BIN},
        {32'h0000_0000, MODE_SDEC}, {32'h7FFF_FFFF, MODE_SDEC}, {32'h8000_0000, MODE_SDEC},
        {32'hFFFF_FFFF, MODE_SDEC},
        {32'h0000_0000, MODE_FIX},  {32'd9999999, MODE_FIX},    {32'd10000000, MODE_FIX},
        {32'h8000_0000, MODE_FIX},  {32'hFFFF_FFFF, MODE_FIX},  {32'd12345, MODE_FIX},
        {32'd42, 3'd5},             {32'hFFFF_FFFF, 3'd6},      {32'h8000_0000, 3'd7}
    };

    number_to_text_formatter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_char(m_tdata[CHAR_W-1:0], m_tlast);
        end
    end

    // result side: m_tready driven low in random bursts and for one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_req <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // called at a rising edge; returns at the rising edge of acceptance or after a gap
    task automatic send_value(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_value(mode, value);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int n);
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                mode = MODE_W'($urandom_range(5, 7));
            end else begin
                mode = MODE_W'($urandom_range(0, 4));
            end
            case ($urandom_range(0, 4))
                0: value = $urandom_range(0, 20);
                1: value = $urandom >> $urandom_range(1, 31);
                2: value = ~($urandom >> $urandom_range(1, 31));
                3: value = $urandom_range(0, 9999999);
                default: value = $urandom;
            endcase
            send_value(mode, value);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        hold_req = 1'b0;
        stall_on = 1'b1;
        gaps_on  = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_value(DIRECTED[i][2:0], DIRECTED[i][34:3]);
        end
        send_random(100);

        // long output stall while items keep coming, so the input backs up
        hold_req <= 1'b1;
        gaps_on = 1'b0;
        send_random(16);
        gaps_on = 1'b1;

        // sender waits for the block to empty completely
        drain_results();
        send_random(94);

        stall_on <= 1'b0;
        gaps_on = 1'b0;
        send_random(40);

        drain_results();
        repeat (100) @(posedge aclk);

        $display("Formatted %0d values (all modes, unused mode codes, edge values) into %0d chars",
                 sb.values_noted, sb.chars_checked);
        $display("with random stalls on both sides and one long output hold-off");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/txt_pkg.sv
rtl/txt_bcd.sv
rtl/txt_seq.sv
rtl/number_to_text_formatter.sv
verif/tb_top.sv
